/* hdl/brd_pkg.sv */
// shared types and constants for the byte order roughness detector
package brd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 32;
    localparam int RATIO_W  = 16;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // request taken on the input channel
        logic div_load;  // pick larger/smaller sum, start the divider
        logic div_step;  // one quotient bit
        logic out_load;  // capture result, clear row state
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_last;  // current step produces the final quotient bit
    } t_status;

endpackage

/* hdl/byte_order_roughness_detector.sv */
// byte order roughness detector: one row of byte pairs in, one decision out
// throughput: one byte pair per cycle within a row
// row end: input stalls after the last pair through the divider load, the
//   one-bit-per-cycle ratio divider (32 + RATIO_FRAC_BITS steps) and the result load,
//   which waits while a held result is stalled at the output; the result is valid once loaded
// reset: synchronous active low, clears row sums and output valid, header flag to 1
module byte_order_roughness_detector
    import brd_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_first_byte,
    input  logic [7:0]         i_second_byte,
    input  logic               i_last_pair,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_data_little_endian,
    output logic               o_order_overridden,
    output logic               o_decided,
    output logic [RATIO_W-1:0] o_smoothness_ratio,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    brd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_pair (i_last_pair),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    brd_datapath #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_first_byte         (i_first_byte),
        .i_second_byte        (i_second_byte),
        .i_cfg_write          (i_cfg_valid),
        .i_cfg_data           (i_cfg_data),
        .o_data_little_endian (o_data_little_endian),
        .o_order_overridden   (o_order_overridden),
        .o_decided            (o_decided),
        .o_smoothness_ratio   (o_smoothness_ratio)
    );

endmodule

/* hdl/brd_ctrl.sv */
// controller state machine: row intake, division sequencing, output hand-off
module brd_ctrl
    import brd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_pair,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_ROW   = 2'd0;
    localparam logic [1:0] S_DLOAD = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_load;

    assign o_in_stall  = (r_state != S_ROW);
    assign accept      = i_in_valid && (r_state == S_ROW);
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.div_load = (r_state == S_DLOAD);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = out_load;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_ROW: begin
                if (accept && i_last_pair) begin
                    n_state = S_DLOAD;
                end
            end
            S_DLOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_ROW;
                end
            end
            default: begin
                n_state = S_ROW;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ROW;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hdl/brd_datapath.sv */
// datapath: roughness sums, bit-serial ratio divider, result registers
module brd_datapath
    import brd_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [7:0]         i_first_byte,
    input  logic [7:0]         i_second_byte,
    input  logic               i_cfg_write,
    input  logic               i_cfg_data,
    output logic               o_data_little_endian,
    output logic               o_order_overridden,
    output logic               o_decided,
    output logic [RATIO_W-1:0] o_smoothness_ratio
);

    localparam int NUM_W = SUM_W + RATIO_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [RATIO_W-1:0] RATIO_ONE = (RATIO_FRAC_BITS >= RATIO_W) ?
        {RATIO_W{1'b1}} : RATIO_W'(1 << RATIO_FRAC_BITS);

    logic                r_header_le;
    logic [SAMPLE_W-1:0] r_prev_little;
    logic [SAMPLE_W-1:0] r_prev_big;
    logic                r_have_prev;
    logic [SUM_W-1:0]    r_sum_little;
    logic [SUM_W-1:0]    r_sum_big;

    logic [SAMPLE_W-1:0] little_v;
    logic [SAMPLE_W-1:0] big_v;
    logic [SAMPLE_W-1:0] diff_little;
    logic [SAMPLE_W-1:0] diff_big;
    logic [SUM_W:0]      add_little;
    logic [SUM_W:0]      add_big;
    logic [SUM_W-1:0]    n_sum_little;
    logic [SUM_W-1:0]    n_sum_big;

    // divider state
    logic [NUM_W-1:0]    r_nq;
    logic [SUM_W-1:0]    r_rem;
    logic [SUM_W-1:0]    r_divisor;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_little;
    logic                r_both_zero;
    logic                r_small_zero;

    logic [SUM_W:0]      rem_sh;
    logic                q_bit;
    logic [SUM_W:0]      rem_sub;
    logic                sum_le;
    logic [SUM_W-1:0]    larger;
    logic [SUM_W-1:0]    smaller;
    logic [RATIO_W-1:0]  quo_sat;

    logic                r_out_le;
    logic                r_out_over;
    logic                r_out_dec;
    logic [RATIO_W-1:0]  r_out_ratio;

    assign little_v    = {i_second_byte, i_first_byte};
    assign big_v       = {i_first_byte, i_second_byte};
    assign diff_little = (little_v >= r_prev_little) ? (little_v - r_prev_little)
                                                     : (r_prev_little - little_v);
    assign diff_big    = (big_v >= r_prev_big) ? (big_v - r_prev_big)
                                               : (r_prev_big - big_v);
    assign add_little  = {1'b0, r_sum_little} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, diff_little};
    assign add_big     = {1'b0, r_sum_big} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, diff_big};
    // saturate on carry out
    assign n_sum_little = add_little[SUM_W] ? {SUM_W{1'b1}} : add_little[SUM_W-1:0];
    assign n_sum_big    = add_big[SUM_W] ? {SUM_W{1'b1}} : add_big[SUM_W-1:0];

    assign sum_le  = (r_sum_little <= r_sum_big);
    assign larger  = sum_le ? r_sum_big : r_sum_little;
    assign smaller = sum_le ? r_sum_little : r_sum_big;

    // restoring division, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_nq[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_divisor};
    assign q_bit   = (rem_sh >= {1'b0, r_divisor});

    assign o_status.div_last = (r_cnt == '0);

    assign quo_sat = (|r_nq[NUM_W-1:RATIO_W]) ? {RATIO_W{1'b1}} : r_nq[RATIO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_le <= 1'b1;
        end else if (i_cfg_write) begin
            r_header_le <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_little <= '0;
            r_prev_big    <= '0;
            r_have_prev   <= 1'b0;
            r_sum_little  <= '0;
            r_sum_big     <= '0;
        end else if (i_cmd.out_load) begin
            r_prev_little <= '0;
            r_prev_big    <= '0;
            r_have_prev   <= 1'b0;
            r_sum_little  <= '0;
            r_sum_big     <= '0;
        end else if (i_cmd.accept) begin
            r_prev_little <= little_v;
            r_prev_big    <= big_v;
            r_have_prev   <= 1'b1;
            if (r_have_prev) begin
                r_sum_little <= n_sum_little;
                r_sum_big    <= n_sum_big;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_nq         <= {larger, {RATIO_FRAC_BITS{1'b0}}};
            r_rem        <= '0;
            r_divisor    <= smaller;
            r_cnt        <= CNT_W'(NUM_W - 1);
            r_little     <= sum_le;
            r_both_zero  <= (r_sum_little == '0) && (r_sum_big == '0);
            r_small_zero <= (smaller == '0);
        end else if (i_cmd.div_step) begin
            r_nq  <= {r_nq[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_both_zero) begin
                r_out_le    <= r_header_le;
                r_out_over  <= 1'b0;
                r_out_dec   <= 1'b0;
                r_out_ratio <= '0;
            end else begin
                r_out_le    <= r_little;
                r_out_over  <= (r_little != r_header_le);
                r_out_dec   <= 1'b1;
                r_out_ratio <= r_small_zero ? RATIO_ONE : quo_sat;
            end
        end
    end

    assign o_data_little_endian = r_out_le;
    assign o_order_overridden   = r_out_over;
    assign o_decided            = r_out_dec;
    assign o_smoothness_ratio   = r_out_ratio;

endmodule

/* sim/byte_order_roughness_checker.sv */
// checker for the byte order roughness detector: predicts each row decision and compares
module byte_order_roughness_checker
    import brd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_first_byte,
    input  logic [7:0]         i_second_byte,
    input  logic               i_last_pair,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_data_little_endian,
    input  logic               i_order_overridden,
    input  logic               i_decided,
    input  logic [RATIO_W-1:0] i_smoothness_ratio,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_undecided,
    output int                 o_overridden
);

    localparam int FRAC_BITS = 8;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic               little_endian;
        logic               overridden;
        logic               decided;
        logic [RATIO_W-1:0] ratio;
    } t_decision;

    t_decision decisions_due[$];

    logic                header_le;
    logic [SAMPLE_W-1:0] prev_le_value;
    logic [SAMPLE_W-1:0] prev_be_value;
    logic                have_prev;
    logic [SUM_W-1:0]    rough_le;
    logic [SUM_W-1:0]    rough_be;
    int                  fails;
    int                  checked;
    int                  undecided;
    int                  overridden;

    function automatic logic [SUM_W-1:0] sat_accumulate(input logic [SUM_W-1:0] acc,
                                                        input logic [SAMPLE_W-1:0] a,
                                                        input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W-1:0] diff;
        logic [SUM_W:0]      total;
        diff  = (a >= b) ? a - b : b - a;
        total = {1'b0, acc} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, diff};
        return total[SUM_W] ? '1 : total[SUM_W-1:0];
    endfunction

    function automatic logic [RATIO_W-1:0] ratio_of(input logic [SUM_W-1:0] larger,
                                                    input logic [SUM_W-1:0] smaller);
        logic [SUM_W+FRAC_BITS-1:0] quotient;
        if (smaller == '0) begin
            quotient = (SUM_W+FRAC_BITS)'(1) << FRAC_BITS;
        end else begin
            quotient = {larger, {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, smaller};
        end
        return (|quotient[SUM_W+FRAC_BITS-1:RATIO_W]) ? '1 : quotient[RATIO_W-1:0];
    endfunction

    task automatic clear_row();
        prev_le_value = '0;
        prev_be_value = '0;
        have_prev     = 1'b0;
        rough_le      = '0;
        rough_be      = '0;
    endtask

    task automatic take_pair(input logic [7:0] fb, input logic [7:0] sb, input logic last);
        logic [SAMPLE_W-1:0] le_value;
        logic [SAMPLE_W-1:0] be_value;
        t_decision           d;
        le_value = {sb, fb};
        be_value = {fb, sb};
        if (have_prev) begin
            rough_le = sat_accumulate(rough_le, le_value, prev_le_value);
            rough_be = sat_accumulate(rough_be, be_value, prev_be_value);
        end
        prev_le_value = le_value;
        prev_be_value = be_value;
        have_prev     = 1'b1;
        if (last) begin
            if (rough_le == '0 && rough_be == '0) begin
                d = '{little_endian: header_le, overridden: 1'b0, decided: 1'b0, ratio: '0};
            end else begin
                // ties go to little endian
                d.little_endian = (rough_le <= rough_be);
                d.ratio         = d.little_endian ? ratio_of(rough_be, rough_le)
                                                  : ratio_of(rough_le, rough_be);
                d.overridden    = (d.little_endian != header_le);
                d.decided       = 1'b1;
            end
            decisions_due = {decisions_due, d};
            clear_row();
        end
    endtask

    task automatic check_decision();
        t_decision want;
        if (decisions_due.size() == 0) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
                $display("unexpected result: le=%0b ovr=%0b dec=%0b ratio=%h",
                         i_data_little_endian, i_order_overridden, i_decided,
                         i_smoothness_ratio);
            end
        end else begin
            want = decisions_due.pop_front();
            checked++;
            if (!want.decided) undecided++;
            if (want.overridden) overridden++;
            if (i_data_little_endian !== want.little_endian ||
                i_order_overridden !== want.overridden ||
                i_decided !== want.decided ||
                i_smoothness_ratio !== want.ratio) begin
                fails++;
                if (fails <= MAX_REPORTS) begin
                    $display("mismatch on decision %0d: expected le=%0b ovr=%0b dec=%0b ratio=%h",
                             checked, want.little_endian, want.overridden, want.decided,
                             want.ratio);
                    $display("    got le=%0b ovr=%0b dec=%0b ratio=%h",
                             i_data_little_endian, i_order_overridden,
                             i_decided, i_smoothness_ratio);
                end
            end
        end
    endtask

    initial begin
        fails      = 0;
        checked    = 0;
        undecided  = 0;
        overridden = 0;
        header_le  = 1'b1;
        clear_row();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            header_le = 1'b1;
            clear_row();
            decisions_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                take_pair(i_first_byte, i_second_byte, i_last_pair);
            end
            if (i_out_valid && !i_out_stall) begin
                check_decision();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                header_le = i_cfg_data;
            end
        end
        o_pending    <= decisions_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_undecided  <= undecided;
        o_overridden <= overridden;
    end

endmodule

/* sim/byte_order_roughness_detector_test.sv */
// testbench top for the byte order roughness detector: stimulus, stall pattern and verdict
module byte_order_roughness_detector_test
    import brd_pkg::*;
();

    localparam int ROW_END_CYCLES = 34 + 8 + 6;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_PAIRS    = 215;

    typedef enum {ROW_LITTLE_WALK, ROW_BIG_WALK, ROW_NOISE, ROW_FLAT, ROW_RAILS} t_row_kind;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_first_byte = '0;
    logic [7:0]         i_second_byte = '0;
    logic               i_last_pair = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_data_little_endian;
    logic               o_order_overridden;
    logic               o_decided;
    logic [RATIO_W-1:0] o_smoothness_ratio;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int undecided;
    int overridden;

    int pairs_sent;
    int rows_sent;
    int header_writes;
    int burst_left;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          run_left = 0;
    logic        run_level = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    byte_order_roughness_detector u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_first_byte         (i_first_byte),
        .i_second_byte        (i_second_byte),
        .i_last_pair          (i_last_pair),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_data_little_endian (o_data_little_endian),
        .o_order_overridden   (o_order_overridden),
        .o_decided            (o_decided),
        .o_smoothness_ratio   (o_smoothness_ratio),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data)
    );

    byte_order_roughness_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_first_byte         (i_first_byte),
        .i_second_byte        (i_second_byte),
        .i_last_pair          (i_last_pair),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_data_little_endian (o_data_little_endian),
        .i_order_overridden   (o_order_overridden),
        .i_decided            (o_decided),
        .i_smoothness_ratio   (o_smoothness_ratio),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data),
        .o_fail_count         (fail_count),
        .o_pending            (pending),
        .o_checked            (checked),
        .o_undecided          (undecided),
        .o_overridden         (overridden)
    );

    // receiver stall pattern: segments of differing stall density
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(32, 200);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            STALL_RUNS: begin
                if (run_left == 0) begin
                    run_left  = $urandom_range(1, 20);
                    run_level = ~run_level;
                end
                run_left--;
                i_out_stall <= run_level;
            end
            default:     i_out_stall <= 1'b0;
        endcase
    end

    task automatic send_pair(input logic [7:0] fb, input logic [7:0] sb, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid    <= 1'b1;
        i_first_byte  <= fb;
        i_second_byte <= sb;
        i_last_pair   <= last;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        pairs_sent++;
        if (last) rows_sent++;
    endtask

    // hold the sender until every decision has come back and the divider is done
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (ROW_END_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header(input logic le);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= le;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        header_writes++;
    endtask

    task automatic send_row(input t_row_kind kind, input int len);
        logic [15:0] v;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  fb;
        logic [7:0]  sb;
        int          s;
        v  = 16'($urandom);
        c0 = 8'($urandom);
        c1 = 8'($urandom);
        s  = 1 << $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
            case (kind)
                ROW_LITTLE_WALK: begin
                    fb = v[7:0];
                    sb = v[15:8];
                end
                ROW_BIG_WALK: begin
                    fb = v[15:8];
                    sb = v[7:0];
                end
                ROW_NOISE: begin
                    fb = 8'($urandom);
                    sb = 8'($urandom);
                end
                ROW_FLAT: begin
                    fb = c0;
                    sb = c1;
                end
                default: begin
                    fb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    sb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
            endcase
            send_pair(fb, sb, i == len - 1);
            v = v + 16'($urandom_range(0, 2 * s)) - 16'(s);
        end
    endtask

    // smooth ramps in one reading, single-pair rows, flat rows and ties
    task automatic directed_rows();
        send_pair(8'hFF, 8'h00, 1'b1);
        repeat (2) send_pair(8'h12, 8'h34, 1'b0);
        send_pair(8'h12, 8'h34, 1'b1);
        send_pair(8'h00, 8'h00, 1'b0);
        send_pair(8'h01, 8'h00, 1'b0);
        send_pair(8'h02, 8'h00, 1'b1);
        send_pair(8'h00, 8'h00, 1'b0);
        send_pair(8'h00, 8'h01, 1'b0);
        send_pair(8'h00, 8'h02, 1'b1);
        send_pair(8'h01, 8'h01, 1'b0);
        send_pair(8'hFF, 8'hFF, 1'b1);
        send_pair(8'h00, 8'hFF, 1'b0);
        send_pair(8'hFF, 8'h00, 1'b1);
        send_pair(8'h00, 8'h10, 1'b0);
        send_pair(8'h03, 8'h10, 1'b0);
        send_pair(8'h00, 8'h11, 1'b1);
        drain();
        write_header(1'b0);
        send_pair(8'h00, 8'h00, 1'b1);
        send_pair(8'h00, 8'h00, 1'b0);
        send_pair(8'h00, 8'h01, 1'b1);
        send_pair(8'h80, 8'h00, 1'b0);
        send_pair(8'h81, 8'h00, 1'b1);
    endtask

    initial begin
        int        phase_start;
        int        pick;
        int        len;
        t_row_kind kind;
        pairs_sent    = 0;
        rows_sent     = 0;
        header_writes = 0;
        burst_left    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_rows();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            write_header((p < 4) ? p[0] : 1'($urandom_range(0, 1)));
            phase_start = pairs_sent;
            while (pairs_sent - phase_start < PHASE_PAIRS) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) kind = ROW_LITTLE_WALK;
                else if (pick < 70) kind = ROW_BIG_WALK;
                else if (pick < 80) kind = ROW_NOISE;
                else if (pick < 90) kind = ROW_FLAT;
                else kind = ROW_RAILS;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160)
                                                  : $urandom_range(1, 24);
                send_row(kind, len);
            end
        end

        drain();
        $display("sent %0d byte pairs in %0d rows across %0d header flag settings",
                 pairs_sent, rows_sent, header_writes + 1);
        $display("checked %0d decisions, %0d undecided rows, %0d header overrides",
                 checked, undecided, overridden);
        if (fail_count == 0 && pending == 0) begin
            $display("byte_order_roughness_detector regression: pass");
        end else begin
            $display("byte_order_roughness_detector regression: fail");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("timeout with %0d decisions outstanding", pending);
        $display("byte_order_roughness_detector regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/brd_pkg.sv
hdl/brd_ctrl.sv
hdl/brd_datapath.sv
hdl/byte_order_roughness_detector.sv
sim/byte_order_roughness_checker.sv
sim/byte_order_roughness_detector_test.sv
